[rtl/assert_macros.svh]
// assertion macros shared by the rvc rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/rvc_pkg.sv]
// types, constants and helper functions of the roi color vote block
`default_nettype none

package rvc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	localparam int CFG_W     = 11;
	localparam int THR_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CHAN_W    = 8;
	localparam int DIST_W    = CHAN_W + 2;
	localparam int TALLY_W   = 21;

	// compare width for column + 1 against the effective row length
	localparam int WRAP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
	// signed compare width for the box test
	localparam int POS_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int BOX_W  = (POS_W + 1 > CFG_W + 2) ? POS_W + 1 : CFG_W + 2;

	localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
	localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(30);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int NUM_COLORS = 3;

	typedef logic [CHAN_W-1:0] chan_t;

	// reference colors as blue, green, red
	localparam chan_t REF_COLOR [NUM_COLORS][3] = '{
		'{8'd115, 8'd191, 8'd57},
		'{8'd67,  8'd176, 8'd208},
		'{8'd55,  8'd49,  8'd208}
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_BOX_LEFT        = 3'd1,
		REG_BOX_TOP         = 3'd2,
		REG_BOX_WIDTH       = 3'd3,
		REG_BOX_HEIGHT      = 3'd4,
		REG_MATCH_THRESHOLD = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		LIGHT_GREEN  = 2'd0,
		LIGHT_ORANGE = 2'd1,
		LIGHT_RED    = 2'd2,
		LIGHT_NONE   = 2'd3
	} light_t;

	typedef struct packed {
		logic        [CFG_W-1:0] image_width;
		logic signed [CFG_W-1:0] box_left;
		logic signed [CFG_W-1:0] box_top;
		logic        [CFG_W-1:0] box_width;
		logic        [CFG_W-1:0] box_height;
		logic        [THR_W-1:0] match_threshold;
	} cfg_t;

	// classified pixel passed from front to back
	typedef struct packed {
		light_t hit;
		logic   frame_end;
	} cls_t;

	// queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic chan_t abs_diff(input chan_t a, input chan_t b);
		return (a > b) ? chan_t'(a - b) : chan_t'(b - a);
	endfunction

endpackage

`default_nettype wire

[rtl/rvc_ifs.sv]
// valid/ready channel interfaces: pixel in, vote out, register write
`default_nettype none

interface rvc_pix_if;
	import rvc_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] red;
	logic              frame_end;
	modport source (output valid, blue, green, red, frame_end, input ready);
	modport sink (input valid, blue, green, red, frame_end, output ready);
endinterface

interface rvc_vote_if;
	import rvc_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         signal_color;
	logic [TALLY_W-1:0] green_hits;
	logic [TALLY_W-1:0] orange_hits;
	logic [TALLY_W-1:0] red_hits;
	modport source (output valid, signal_color, green_hits, orange_hits, red_hits, input ready);
	modport sink (input valid, signal_color, green_hits, orange_hits, red_hits, output ready);
endinterface

interface rvc_cfg_if;
	import rvc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/rvc_front.sv]
// front: position tracking, box test and color classification
`default_nettype none

module rvc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  rvc_pkg::cfg_t cfg,
	rvc_pix_if.sink       pix,
	input  rvc_pkg::q_stat_t q_stat,
	output logic          push,
	output rvc_pkg::cls_t push_data
);
	import rvc_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic              valid_s1;
	chan_t             blue_s1;
	chan_t             green_s1;
	chan_t             red_s1;
	logic              in_box_s1;
	logic              frame_end_s1;

	logic              accept;
	logic [WRAP_W-1:0] eff_w;
	logic [WRAP_W-1:0] col_inc;
	logic [ROW_W:0]    row_inc;

	logic signed [BOX_W-1:0] col_s;
	logic signed [BOX_W-1:0] row_s;
	logic signed [BOX_W-1:0] left_s;
	logic signed [BOX_W-1:0] right_s;
	logic signed [BOX_W-1:0] top_s;
	logic signed [BOX_W-1:0] bottom_s;
	logic                    in_box;

	logic [DIST_W-1:0] color_dist [NUM_COLORS];
	logic [NUM_COLORS-1:0] match;

	assign pix.ready = !valid_s1 || !q_stat.full;
	assign accept    = pix.valid && pix.ready;
	assign push      = valid_s1 && !q_stat.full;

	// effective row length: zero acts as one, clamp at the maximum
	always_comb begin
		if (cfg.image_width == '0) begin
			eff_w = WRAP_W'(1);
		end else if (WRAP_W'(cfg.image_width) > WRAP_W'(MAX_WIDTH)) begin
			eff_w = WRAP_W'(MAX_WIDTH);
		end else begin
			eff_w = WRAP_W'(cfg.image_width);
		end
	end

	assign col_inc = WRAP_W'(col_q) + WRAP_W'(1);
	assign row_inc = {1'b0, row_q} + (ROW_W+1)'(1);

	// box test on the current position
	assign col_s    = signed'(BOX_W'(col_q));
	assign row_s    = signed'(BOX_W'(row_q));
	assign left_s   = BOX_W'(cfg.box_left);
	assign top_s    = BOX_W'(cfg.box_top);
	assign right_s  = left_s + signed'(BOX_W'(cfg.box_width));
	assign bottom_s = top_s + signed'(BOX_W'(cfg.box_height));
	assign in_box   = (col_s >= left_s) && (col_s < right_s) &&
	                  (row_s >= top_s) && (row_s < bottom_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (pix.frame_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (col_inc >= eff_w) begin
					col_q <= '0;
					if (row_inc < (ROW_W+1)'(MAX_HEIGHT)) begin
						row_q <= row_inc[ROW_W-1:0];
					end
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blue_s1      <= pix.blue;
			green_s1     <= pix.green;
			red_s1       <= pix.red;
			in_box_s1    <= in_box;
			frame_end_s1 <= pix.frame_end;
		end
	end

	// sum of absolute channel differences against each reference
	always_comb begin
		for (int k = 0; k < NUM_COLORS; k++) begin
			color_dist[k] = DIST_W'(abs_diff(blue_s1, REF_COLOR[k][0])) +
			                DIST_W'(abs_diff(green_s1, REF_COLOR[k][1])) +
			                DIST_W'(abs_diff(red_s1, REF_COLOR[k][2]));
			match[k] = in_box_s1 && (color_dist[k] < cfg.match_threshold);
		end
	end

	// first match wins, in the order green, orange, red
	always_comb begin
		push_data.frame_end = frame_end_s1;
		priority if (match[0]) begin
			push_data.hit = LIGHT_GREEN;
		end else if (match[1]) begin
			push_data.hit = LIGHT_ORANGE;
		end else if (match[2]) begin
			push_data.hit = LIGHT_RED;
		end else begin
			push_data.hit = LIGHT_NONE;
		end
	end

endmodule

`default_nettype wire

[rtl/rvc_fifo.sv]
// short queue of classified pixels between front and back
`default_nettype none
`include "assert_macros.svh"

module rvc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  rvc_pkg::cls_t     wr_data,
	input  logic              rd_en,
	output rvc_pkg::cls_t     rd_data,
	output rvc_pkg::q_stat_t  stat
);
	import rvc_pkg::*;

	cls_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign stat.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`ASSERT_NEVER(a_fifo_overflow, wr_en && stat.full, "write into full queue")
	`ASSERT_NEVER(a_fifo_underflow, rd_en && stat.empty, "read from empty queue")
	`ASSERT_ALWAYS(a_fifo_count, (wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1), "count lost a write")

endmodule

`default_nettype wire

[rtl/rvc_back.sv]
// back: tally update, majority vote and result register
`default_nettype none
`include "assert_macros.svh"

module rvc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rvc_pkg::cls_t    head,
	input  rvc_pkg::q_stat_t q_stat,
	output logic             pop,
	rvc_vote_if.source       vote
);
	import rvc_pkg::*;

	logic [TALLY_W-1:0] green_tally_q;
	logic [TALLY_W-1:0] orange_tally_q;
	logic [TALLY_W-1:0] red_tally_q;
	logic [TALLY_W-1:0] green_nxt;
	logic [TALLY_W-1:0] orange_nxt;
	logic [TALLY_W-1:0] red_nxt;

	logic               vote_valid_q;
	light_t             light_q;
	logic [TALLY_W-1:0] green_hits_q;
	logic [TALLY_W-1:0] orange_hits_q;
	logic [TALLY_W-1:0] red_hits_q;

	logic               out_free;
	light_t             light_nxt;

	// a frame end needs the result register, other items never stall
	assign out_free = !vote_valid_q || vote.ready;
	assign pop      = !q_stat.empty && (!head.frame_end || out_free);

	// saturating tally increment
	always_comb begin
		green_nxt  = green_tally_q;
		orange_nxt = orange_tally_q;
		red_nxt    = red_tally_q;
		unique case (head.hit)
			LIGHT_GREEN:  if (green_tally_q != TALLY_MAX) green_nxt = green_tally_q + 1'b1;
			LIGHT_ORANGE: if (orange_tally_q != TALLY_MAX) orange_nxt = orange_tally_q + 1'b1;
			LIGHT_RED:    if (red_tally_q != TALLY_MAX) red_nxt = red_tally_q + 1'b1;
			default:      ;
		endcase
	end

	// strictly highest tally wins, anything else is none
	always_comb begin
		priority if (green_nxt > orange_nxt && green_nxt > red_nxt) begin
			light_nxt = LIGHT_GREEN;
		end else if (orange_nxt > green_nxt && orange_nxt > red_nxt) begin
			light_nxt = LIGHT_ORANGE;
		end else if (red_nxt > green_nxt && red_nxt > orange_nxt) begin
			light_nxt = LIGHT_RED;
		end else begin
			light_nxt = LIGHT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_tally_q  <= '0;
			orange_tally_q <= '0;
			red_tally_q    <= '0;
			vote_valid_q   <= 1'b0;
		end else begin
			if (pop && head.frame_end) begin
				green_tally_q  <= '0;
				orange_tally_q <= '0;
				red_tally_q    <= '0;
				vote_valid_q   <= 1'b1;
			end else begin
				if (pop) begin
					green_tally_q  <= green_nxt;
					orange_tally_q <= orange_nxt;
					red_tally_q    <= red_nxt;
				end
				if (vote.ready) begin
					vote_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.frame_end) begin
			light_q       <= light_nxt;
			green_hits_q  <= green_nxt;
			orange_hits_q <= orange_nxt;
			red_hits_q    <= red_nxt;
		end
	end

	assign vote.valid        = vote_valid_q;
	assign vote.signal_color = light_q;
	assign vote.green_hits   = green_hits_q;
	assign vote.orange_hits  = orange_hits_q;
	assign vote.red_hits     = red_hits_q;

	`ASSERT_ALWAYS(a_back_clear, (pop && head.frame_end) |=> (green_tally_q == '0 && orange_tally_q == '0 && red_tally_q == '0), "tallies not cleared after frame end")
	`ASSERT_ALWAYS(a_back_green, (vote_valid_q && light_q == LIGHT_GREEN) |-> (green_hits_q > orange_hits_q && green_hits_q > red_hits_q), "green vote without a strict majority")
	`ASSERT_ALWAYS(a_back_rise, $rose(vote_valid_q) |-> $past(pop && head.frame_end), "result without a frame end")

endmodule

`default_nettype wire

[rtl/roi_traffic_light_color_vote_core.sv]
// top level of the roi traffic light color vote block
`default_nettype none

// channel  dir  payload                                           moves
// pix      in   blue, green, red, frame_end                       one pixel item
// vote     out  signal_color, green_hits, orange_hits, red_hits   one result item per frame
// cfg      in   index, data                                       one register write
//
// one pixel item per clock sustained while the queue has room; after acceptance a pixel reaches the tallies
// (position and box test into stage 1, classify into the queue, tally as it leaves the queue)
// a frame's vote is registered as its last pixel leaves the queue and the vote register is free;
// reset clears position, tallies, queue and result valid
// only a last pixel waits on a busy vote register; the four-entry queue absorbs that until it
// fills, then pix.ready drops; cfg.ready is always high and registers reset to their defaults

module roi_traffic_light_color_vote_core (
	input  logic       clk,
	input  logic       arst_n,
	rvc_pix_if.sink    pix,
	rvc_vote_if.source vote,
	rvc_cfg_if.sink    cfg
);
	import rvc_pkg::*;

	cfg_t    cfg_q;
	logic    push;
	logic    pop;
	cls_t    push_data;
	cls_t    head;
	q_stat_t q_stat;

	// register file, writes outside the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= WIDTH_RESET;
			cfg_q.box_left        <= '0;
			cfg_q.box_top         <= '0;
			cfg_q.box_width       <= '0;
			cfg_q.box_height      <= '0;
			cfg_q.match_threshold <= THRESH_RESET;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg.data;
				REG_BOX_LEFT:        cfg_q.box_left        <= cfg.data;
				REG_BOX_TOP:         cfg_q.box_top         <= cfg.data;
				REG_BOX_WIDTH:       cfg_q.box_width       <= cfg.data;
				REG_BOX_HEIGHT:      cfg_q.box_height      <= cfg.data;
				REG_MATCH_THRESHOLD: cfg_q.match_threshold <= cfg.data[THR_W-1:0];
				default:             ;
			endcase
		end
	end

	// front: tracks column/row, tests the box, classifies each pixel
	rvc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pix       (pix),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// queue decouples pixel intake from result delivery
	rvc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_data),
		.rd_en   (pop),
		.rd_data (head),
		.stat    (q_stat)
	);

	// back: counts hits, votes on the last pixel, holds the result
	rvc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.vote   (vote)
	);

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// self-checking testbench of the roi traffic light color vote block
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rvc_pkg::*;

	// one pixel item as offered on the pix channel
	typedef struct {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
		logic              frame_end;
	} pixel_item_t;

	// one vote item as expected on the vote channel
	typedef struct {
		light_t light;
		int     g_hits;
		int     o_hits;
		int     r_hits;
	} frame_vote_t;

	// reference colors as blue, green, red, in match priority order
	localparam int HUE_BGR [3][3] = '{
		'{115, 191, 57},
		'{67,  176, 208},
		'{55,  49,  208}
	};
	localparam int TALLY_CAP = 2097151;
	localparam int LONG_HOLD = 80;
	localparam int SETTLE_CYCLES = 12;
	// write indexes past the register list, the block must drop these
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic clk;
	logic arst_n;

	rvc_pix_if  pix_ch ();
	rvc_vote_if vote_ch ();
	rvc_cfg_if  cfg_ch ();

	roi_traffic_light_color_vote_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.vote   (vote_ch),
		.cfg    (cfg_ch)
	);

	// pixels waiting for the driver, votes waiting for the vote channel
	pixel_item_t pix_pend_q [$];
	frame_vote_t vote_exp_q [$];

	// shadow of the block: registers, position and tallies
	int img_w   = 1024;
	int box_x   = 0;
	int box_y   = 0;
	int box_w   = 0;
	int box_h   = 0;
	int thr_lim = 30;
	int col_at  = 0;
	int row_at  = 0;
	int hits [3] = '{0, 0, 0};

	int mismatch_cnt = 0;

	// handshakes seen at the last rising edge, used by the falling-edge drivers
	bit pix_took = 1'b0;
	bit cfg_took = 1'b0;

	// sender burst/gap shaping
	int gap_left   = 0;
	int burst_left = 1;
	int gap_max    = 0;

	// receiver stall pattern and long hold-off
	int stall_len = 0;
	int rx_tick   = 0;
	int hold_left = 0;
	int hold_seq  = 0;
	int hold_seen = 0;

	pixel_item_t drv_px;
	pixel_item_t seen_px;
	frame_vote_t want_vote;

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: vote check failed, %s: got %0d, want %0d", $time, what, got, want);
		mismatch_cnt++;
	endtask

	function automatic int chan_gap(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// advance the shadow by one accepted pixel; on frame_end queue the expected vote
	task automatic vote_step(input pixel_item_t p);
		int eff_w;
		int gap_sum;
		bit hit;
		frame_vote_t v;
		eff_w = (img_w == 0) ? 1 : ((img_w > MAX_WIDTH) ? MAX_WIDTH : img_w);
		hit = 1'b0;
		// inside the box: first color under the threshold wins, green before orange before red
		if (col_at >= box_x && col_at < box_x + box_w &&
		    row_at >= box_y && row_at < box_y + box_h) begin
			for (int k = 0; k < 3; k++) begin
				gap_sum = chan_gap(int'(p.blue), HUE_BGR[k][0]) +
				          chan_gap(int'(p.green), HUE_BGR[k][1]) +
				          chan_gap(int'(p.red), HUE_BGR[k][2]);
				if (!hit && gap_sum < thr_lim) begin
					hit = 1'b1;
					if (hits[k] < TALLY_CAP)
						hits[k]++;
				end
			end
		end
		if (p.frame_end) begin
			// strict majority only, ties and empty frames give none
			if (hits[0] > hits[1] && hits[0] > hits[2])
				v.light = LIGHT_GREEN;
			else if (hits[1] > hits[0] && hits[1] > hits[2])
				v.light = LIGHT_ORANGE;
			else if (hits[2] > hits[0] && hits[2] > hits[1])
				v.light = LIGHT_RED;
			else
				v.light = LIGHT_NONE;
			v.g_hits = hits[0];
			v.o_hits = hits[1];
			v.r_hits = hits[2];
			vote_exp_q.push_back(v);
			hits = '{0, 0, 0};
			col_at = 0;
			row_at = 0;
		end else if (col_at + 1 >= eff_w) begin
			// row wrap, row count sticks on the last row
			col_at = 0;
			if (row_at + 1 < MAX_HEIGHT)
				row_at++;
		end else begin
			col_at++;
		end
	endtask

	// pixel near one of the reference colors, fully random, or at the channel extremes
	function automatic pixel_item_t make_px(input bit last);
		pixel_item_t p;
		int kind;
		int v [3];
		kind = $urandom_range(0, 4);
		for (int i = 0; i < 3; i++) begin
			if (kind < 3)
				v[i] = HUE_BGR[kind][i] + int'($urandom_range(0, 30)) - 15;
			else if (kind == 3)
				v[i] = int'($urandom_range(0, 255));
			else
				v[i] = int'($urandom_range(0, 1)) * 255;
			if (v[i] < 0)
				v[i] = 0;
			if (v[i] > 255)
				v[i] = 255;
		end
		p.blue = CHAN_W'(v[0]);
		p.green = CHAN_W'(v[1]);
		p.red = CHAN_W'(v[2]);
		p.frame_end = last;
		return p;
	endfunction

	task automatic push_px(input int b, input int g, input int r, input bit last);
		pixel_item_t p;
		p.blue = CHAN_W'(b);
		p.green = CHAN_W'(g);
		p.red = CHAN_W'(r);
		p.frame_end = last;
		pix_pend_q.push_back(p);
	endtask

	// queue a run of pixels; close marks the last one as frame end
	task automatic queue_frame(input int len, input bit close);
		for (int i = 0; i < len; i++)
			pix_pend_q.push_back(make_px(close && i == len - 1));
	endtask

	// one register write, entered and left at a falling edge
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= CFG_W'(val);
		do @(negedge clk); while (!cfg_took);
	endtask

	// full register set, plus writes to the unused indexes which must be ignored
	task automatic load_cfg(input int w, input int left, input int top, input int bw,
	                        input int bh, input int thr);
		@(negedge clk);
		put_reg(REG_SPARE_LO, $urandom_range(0, 2047));
		put_reg(REG_IMAGE_WIDTH, w);
		put_reg(REG_BOX_LEFT, left);
		put_reg(REG_BOX_TOP, top);
		put_reg(REG_SPARE_HI, $urandom_range(0, 2047));
		put_reg(REG_BOX_WIDTH, bw);
		put_reg(REG_BOX_HEIGHT, bh);
		put_reg(REG_MATCH_THRESHOLD, thr);
		cfg_ch.valid <= 1'b0;
	endtask

	// sender holds until every queued pixel went in and every vote came out,
	// then lets the pipeline empty of trailing pixels of an open frame
	task automatic drain();
		while (pix_pend_q.size() != 0 || pix_ch.valid || vote_exp_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// pixel driver: bursts of random length, random gaps, item held until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else if (!pix_ch.valid || pix_took) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				pix_ch.valid <= 1'b0;
			end else if (pix_pend_q.size() != 0) begin
				drv_px = pix_pend_q.pop_front();
				pix_ch.valid <= 1'b1;
				pix_ch.blue <= drv_px.blue;
				pix_ch.green <= drv_px.green;
				pix_ch.red <= drv_px.red;
				pix_ch.frame_end <= drv_px.frame_end;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left <= (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				pix_ch.valid <= 1'b0;
			end
		end
	end

	// long hold-off of the vote channel, started when hold_seq moves
	always @(negedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_left <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// vote receiver: periodic stall window with random holes, off when stall_len is 0
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		vote_ch.ready <= (hold_left == 0) && ((rx_tick % 8) >= stall_len) &&
		                 (stall_len == 0 || $urandom_range(0, 3) != 0);
	end

	// monitor: all three channels sampled at the rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_took = 1'b0;
			pix_took = 1'b0;
		end else begin
			cfg_took = cfg_ch.valid && cfg_ch.ready;
			pix_took = pix_ch.valid && pix_ch.ready;
			// the user is to write registers only while the block is idle; the block does not enforce it
			if (cfg_took) begin
				case (cfg_ch.index)
					REG_IMAGE_WIDTH:     img_w = int'(cfg_ch.data);
					REG_BOX_LEFT:        box_x = int'($signed(cfg_ch.data));
					REG_BOX_TOP:         box_y = int'($signed(cfg_ch.data));
					REG_BOX_WIDTH:       box_w = int'(cfg_ch.data);
					REG_BOX_HEIGHT:      box_h = int'(cfg_ch.data);
					REG_MATCH_THRESHOLD: thr_lim = int'(cfg_ch.data[THR_W-1:0]);
					default: ;
				endcase
			end
			if (pix_took) begin
				seen_px.blue = pix_ch.blue;
				seen_px.green = pix_ch.green;
				seen_px.red = pix_ch.red;
				seen_px.frame_end = pix_ch.frame_end;
				vote_step(seen_px);
			end
			if (vote_ch.valid && vote_ch.ready) begin
				if (vote_exp_q.size() == 0) begin
					report_mismatch("vote item with no frame pending",
					                int'(vote_ch.signal_color), -1);
				end else begin
					want_vote = vote_exp_q.pop_front();
					if (vote_ch.signal_color !== want_vote.light)
						report_mismatch("signal_color", int'(vote_ch.signal_color),
						                int'(want_vote.light));
					if (vote_ch.green_hits !== TALLY_W'(want_vote.g_hits))
						report_mismatch("green_hits", int'(vote_ch.green_hits),
						                want_vote.g_hits);
					if (vote_ch.orange_hits !== TALLY_W'(want_vote.o_hits))
						report_mismatch("orange_hits", int'(vote_ch.orange_hits),
						                want_vote.o_hits);
					if (vote_ch.red_hits !== TALLY_W'(want_vote.r_hits))
						report_mismatch("red_hits", int'(vote_ch.red_hits), want_vote.r_hits);
				end
			end
		end
	end

	// stimulus
	initial begin
		int w;
		int ew;
		int left;
		int top;
		int bw;
		int bh;
		int thr;
		int n;
		int len;
		bit open;

		clk = 1'b0;
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.blue = '0;
		pix_ch.green = '0;
		pix_ch.red = '0;
		pix_ch.frame_end = 1'b0;
		vote_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults after reset: empty box, so a green frame votes none
		push_px(115, 191, 57, 1'b0);
		push_px(115, 191, 57, 1'b1);
		drain();

		// width zero acts as one pixel per row, box is the single pixel on row 1
		load_cfg(0, 0, 1, 1, 1, 30);
		push_px(115, 191, 57, 1'b0);
		push_px(55, 49, 208, 1'b0);
		push_px(115, 191, 57, 1'b1);
		drain();

		// oversize width clamps, box from the most negative corner, widest threshold
		load_cfg(2047, -1024, -1024, 2047, 2047, 765);
		push_px(0, 0, 0, 1'b0);
		push_px(255, 255, 255, 1'b0);
		push_px(115, 191, 57, 1'b1);
		drain();

		// zero threshold: even an exact color never counts
		load_cfg(4, 0, 0, 4, 4, 0);
		push_px(115, 191, 57, 1'b1);
		drain();

		// tie between green and red, then a clear orange win, then a one-pixel red frame
		load_cfg(4, 0, 0, 4, 4, 30);
		push_px(115, 191, 57, 1'b0);
		push_px(55, 49, 208, 1'b0);
		push_px(0, 0, 0, 1'b1);
		push_px(67, 176, 208, 1'b0);
		push_px(67, 176, 208, 1'b0);
		push_px(115, 191, 57, 1'b1);
		push_px(55, 49, 208, 1'b1);
		drain();

		// random phases: fresh registers, then frames of random content
		for (int ph = 0; ph < 18; ph++) begin
			case ($urandom_range(0, 9))
				0:       w = 0;
				1:       w = 1024;
				2:       w = $urandom_range(1025, 2047);
				default: w = $urandom_range(1, 12);
			endcase
			ew = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
			case ($urandom_range(0, 7))
				0:       left = -1024;
				1:       left = 1023;
				default: left = int'($urandom_range(0, ew + 3)) - 3;
			endcase
			case ($urandom_range(0, 7))
				0:       top = -1024;
				1:       top = 1023;
				default: top = int'($urandom_range(0, 6)) - 2;
			endcase
			case ($urandom_range(0, 7))
				0:       bw = 0;
				1:       bw = 2047;
				default: bw = $urandom_range(1, ew + 2);
			endcase
			case ($urandom_range(0, 7))
				0:       bh = 0;
				1:       bh = 2047;
				default: bh = $urandom_range(1, 6);
			endcase
			// top bit of the data word lies beyond the threshold field
			case ($urandom_range(0, 7))
				0:       thr = 0;
				1:       thr = 765;
				2:       thr = 2047;
				default: thr = $urandom_range(10, 200);
			endcase
			load_cfg(w, left, top, bw, bh, thr);
			case ($urandom_range(0, 3))
				0:       gap_max = 0;
				1:       gap_max = 3;
				default: gap_max = $urandom_range(1, 8);
			endcase
			stall_len = $urandom_range(0, 6);
			n = 0;
			while (n < 25) begin
				len = $urandom_range(1, (3 * ew + 2 > 40) ? 40 : 3 * ew + 2);
				// now and then leave the last frame open so the next width lands mid-frame
				open = (n + len >= 25) && ($urandom_range(0, 4) == 0);
				queue_frame(len, !open);
				n += len;
			end
			drain();
		end

		// back-pressure: vote channel held off while one-pixel frames keep coming
		load_cfg(3, 0, 0, 3, 1, 100);
		gap_max = 0;
		stall_len = 0;
		@(posedge clk);
		hold_seq++;
		for (int i = 0; i < 40; i++)
			queue_frame(1, 1'b1);
		drain();

		if (vote_exp_q.size() != 0)
			report_mismatch("frames left without a vote item", 0, vote_exp_q.size());
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog, far above the slowest correct run
	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end

endmodule
